// File: design/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  localparam int VALUE_W     = 32;
  localparam int VAR_W       = 31;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_NOISE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_SETUP,
    ST_DIV,
    ST_MUL_EST,
    ST_ADD_EST,
    ST_MUL_VAR,
    ST_DONE
  } skf_state_t;

  typedef struct packed {
    logic load_in;
    logic pred;
    logic setup;
    logic div_step;
    logic mul_est;
    logic add_est;
    logic mul_var;
    logic finish;
  } skf_cmd_t;

  typedef struct packed {
    logic div_last;
  } skf_status_t;

endpackage

// File: design/skf_if.sv
// Valid/ready channel interfaces for samples and filter results.
interface skf_sample_if import skf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface skf_result_if import skf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] estimate;
  logic        [VAR_W-1:0]   variance;

  modport source (output valid, output estimate, output variance, input ready);
  modport sink (input valid, input estimate, input variance, output ready);
endinterface

// File: design/skf_ctrl.sv
// Sequencing state machine and output beat flag for the Kalman filter.
module skf_ctrl import skf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output skf_cmd_t    cmd,
  input  skf_status_t status
);

  skf_state_t state, state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_PRED;
      ST_PRED:    state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_DIV;
      ST_DIV:     if (status.div_last) state_next = ST_MUL_EST;
      ST_MUL_EST: state_next = ST_ADD_EST;
      ST_ADD_EST: state_next = ST_MUL_VAR;
      ST_MUL_VAR: state_next = ST_DONE;
      ST_DONE:    if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_PRED:    cmd.pred     = 1'b1;
      ST_SETUP:   cmd.setup    = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_MUL_EST: cmd.mul_est  = 1'b1;
      ST_ADD_EST: cmd.add_est  = 1'b1;
      ST_MUL_VAR: cmd.mul_var  = 1'b1;
      ST_DONE:    cmd.finish   = slot_free;
      default:    cmd          = '0;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: design/skf_dp.sv
// Datapath: configuration, filter state, serial divider and shared multiplier.
module skf_dp import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [VALUE_W-1:0] measurement,
  input  skf_cmd_t                  cmd,
  output skf_status_t               status,
  output logic signed [VALUE_W-1:0] out_estimate,
  output logic [VAR_W-1:0]          out_variance
);

  localparam int GW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int AW = VALUE_W + 2;
  localparam int BW = GW + 1;
  localparam int PW = AW + BW;
  localparam int SW = PW - FRAC_BITS;
  localparam logic [VAR_W-1:0] Q_RESET =
    VAR_W'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [VAR_W-1:0] R_RESET = VAR_W'(64'd7 << FRAC_BITS);
  localparam logic [GW-1:0]    ONE     = GW'(1) << FRAC_BITS;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  logic [VAR_W-1:0]          q_noise;
  logic [VAR_W-1:0]          r_noise;
  logic signed [VALUE_W-1:0] est;
  logic [VAR_W-1:0]          var_st;
  logic signed [VALUE_W-1:0] meas;
  logic [VAR_W-1:0]          pmid;
  logic [VAR_W:0]            denom;
  logic                      denom_zero;
  logic [VAR_W+1:0]          rem;
  logic [GW-1:0]             gain;
  logic [CW-1:0]             cnt;
  logic signed [VALUE_W:0]   diff;
  logic signed [PW-1:0]      prod;

  logic [VAR_W:0]            pmid_sum;
  logic                      rem_ge;
  logic [VAR_W+1:0]          rem_sub;
  logic [VAR_W:0]            rem_keep;
  logic signed [AW-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [SW-1:0]      prod_sh;
  logic signed [SW:0]        est_sum;
  logic signed [VALUE_W-1:0] est_sat;
  logic [VAR_W-1:0]          var_sat;

  assign status.div_last = (cnt == '0);

  assign pmid_sum = {1'b0, var_st} + {1'b0, q_noise};
  assign rem_ge   = !denom_zero && (rem >= {1'b0, denom});
  assign rem_sub  = rem - {1'b0, denom};
  assign rem_keep = rem_ge ? rem_sub[VAR_W:0] : rem[VAR_W:0];

  always_comb begin
    if (cmd.mul_var) begin
      mul_a = AW'({1'b0, pmid});
      mul_b = BW'({1'b0, ONE - gain});
    end else begin
      mul_a = AW'(diff);
      mul_b = BW'({1'b0, gain});
    end
  end

  assign prod_sh = prod[PW-1:FRAC_BITS];
  assign est_sum = (SW+1)'(est) + (SW+1)'(prod_sh);

  always_comb begin
    if (!est_sum[SW] && (|est_sum[SW-1:VALUE_W-1])) begin
      est_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (est_sum[SW] && !(&est_sum[SW-1:VALUE_W-1])) begin
      est_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      est_sat = est_sum[VALUE_W-1:0];
    end
  end

  assign var_sat = (|prod_sh[SW-1:VAR_W]) ? VAR_MAX : prod_sh[VAR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= Q_RESET;
      r_noise <= R_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROCESS_NOISE: q_noise <= cfg_data;
        CFG_MEASURE_NOISE: r_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est    <= '0;
      var_st <= '0;
    end else begin
      if (cmd.add_est) begin
        est <= est_sat;
      end
      if (cmd.finish) begin
        var_st <= var_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas <= measurement;
    end
    if (cmd.pred) begin
      pmid <= pmid_sum[VAR_W] ? VAR_MAX : pmid_sum[VAR_W-1:0];
    end
    if (cmd.setup) begin
      denom      <= {1'b0, pmid} + {1'b0, r_noise};
      denom_zero <= (pmid == '0) && (r_noise == '0);
      rem        <= {2'b00, pmid};
      gain       <= '0;
      cnt        <= CW'(FRAC_BITS);
      diff       <= (VALUE_W+1)'(meas) - (VALUE_W+1)'(est);
    end
    if (cmd.div_step) begin
      rem  <= {rem_keep, 1'b0};
      gain <= {gain[GW-2:0], rem_ge};
      cnt  <= cnt - 1'b1;
    end
    if (cmd.mul_est || cmd.mul_var) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.finish) begin
      out_estimate <= est;
      out_variance <= var_sat;
    end
  end

endmodule

// File: design/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: controller, datapath and channel ports.
//
// The block takes one measurement beat on the sample channel and returns one
// result beat (estimate and updated variance) on the result channel.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data:
// index 0 sets the process noise Q and index 1 the measurement noise R,
// both unsigned fixed point with FRAC_BITS fractional bits. Write them only
// while the filter is idle.
// A sample passes prediction, divider setup, division, estimate multiply,
// estimate add, variance multiply and done; the next is taken only in idle.
// The gain division runs as a restoring divider, one quotient bit per cycle,
// FRAC_BITS + 1 quotient bits in all, and one shared multiplier forms both products.
// Reset clears the estimate and variance, loads Q = 0.02 and R = 7.0 and
// drops the result valid.
// The finished result sits in an output register; the filter accepts and
// works on the next sample while it waits, and holds in its last step until
// the receiver takes the pending beat.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  skf_sample_if.sink             sample,
  skf_result_if.source           result
);

  skf_cmd_t    cmd;
  skf_status_t status;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  skf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .measurement  (sample.measurement),
    .cmd          (cmd),
    .status       (status),
    .out_estimate (result.estimate),
    .out_variance (result.variance)
  );

endmodule

// File: design/skf_checker.sv
// Port-level checks for the scalar Kalman filter and their binding.
module skf_checker import skf_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] estimate,
  input logic [VAR_W-1:0]          variance
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result valid dropped before the beat was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(estimate) && $stable(variance))
    else $error("Result payload changed while stalled.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("Sample accepted while the filter was still working.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_beat))
    else $error("Result appeared in the cycle after its sample.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid not cleared by reset.");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .estimate  (result.estimate),
  .variance  (result.variance)
);
